// ----- rtl/xmt_pkg.sv -----
// Shared types, constants and helpers of the XML markup tokenizer.
package xmt_pkg;

    // Default bound on the number of entity name bytes that are kept
    localparam int ENTITY_NAME_MAX_DEF = 4;

    // Symbol length limit after reset
    localparam logic [7:0] SYM_LIMIT_RESET = 8'd254;

    // Token kinds
    localparam logic [1:0] KIND_SPECIAL = 2'd0;
    localparam logic [1:0] KIND_STRING  = 2'd1;
    localparam logic [1:0] KIND_SYMBOL  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_T = 8'h74;

    // Named entities: name bytes, name length, decoded byte
    localparam int ENT_COUNT = 5;
    localparam int ENT_NAME_LEN = 4;
    localparam logic [7:0] ENT_NAME [ENT_COUNT][ENT_NAME_LEN] = '{
        '{8'h61, 8'h6D, 8'h70, 8'h00},   // amp
        '{8'h6C, 8'h74, 8'h00, 8'h00},   // lt
        '{8'h67, 8'h74, 8'h00, 8'h00},   // gt
        '{8'h71, 8'h75, 8'h6F, 8'h74},   // quot
        '{8'h6E, 8'h62, 8'h73, 8'h70}    // nbsp
    };
    localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd3, 3'd2, 3'd2, 3'd4, 3'd4};
    localparam logic [7:0] ENT_CHAR [ENT_COUNT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h20};

    // Depth of the result queue
    localparam int OUTQ_DEPTH = 4;

    // One input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    // One configuration write
    typedef struct packed {
        logic [7:0] max_symbol_length;
    } cfg_item_t;

    // One result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic [1:0]  token_kind;
        logic        last_of_token;
        logic [15:0] line_number;
        logic        last_of_run;
    } out_item_t;

    // Results of one scanner step
    typedef struct packed {
        logic [1:0] count;
        out_item_t  res0;
        out_item_t  res1;
    } scan_result_t;

    function automatic out_item_t mk_result(
        input logic [7:0]  b,
        input logic        has,
        input logic [1:0]  kind,
        input logic        last,
        input logic [15:0] line
    );
        out_item_t r;
        r.out_byte      = b;
        r.has_byte      = has;
        r.token_kind    = kind;
        r.last_of_token = last;
        r.line_number   = line;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/xmt_stream_if.sv -----
// Valid/ready channel carrying one payload item per transfer.
interface xmt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/xmt_scan.sv -----
// Tokenizer scanner: scan state and the decode of one markup byte.
module xmt_scan #(
    parameter int ENTITY_NAME_MAX = xmt_pkg::ENTITY_NAME_MAX_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  xmt_pkg::in_item_t      item,
    input  logic                   cfg_wr,
    input  logic [7:0]             cfg_data,
    output xmt_pkg::scan_result_t  result
);

    localparam int LENW = $clog2(ENTITY_NAME_MAX + 1);
    localparam int IDXW = $clog2(ENTITY_NAME_MAX);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SYMBOL,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_ENTITY
    } scan_mode_t;

    scan_mode_t       mode_reg, mode_next;
    logic [7:0]       limit_reg;
    logic [7:0]       sym_len_reg, sym_len_next;
    logic [LENW-1:0]  ent_len_reg, ent_len_next;
    logic             ent_long_reg, ent_long_next;
    logic [15:0]      line_reg, line_next;
    logic [7:0]       ent_name_reg [ENTITY_NAME_MAX];
    logic             ent_wr;

    logic [7:0]       c;
    logic             is_ws;
    logic             is_spec;
    logic [7:0]       limit;
    logic [7:0]       sym_len_inc;
    logic             sym_last;
    logic [15:0]      line_inc;
    logic             ent_hit;
    logic [7:0]       ent_char;

    assign c           = item.in_byte;
    assign is_ws       = (c <= xmt_pkg::CH_SPACE);
    assign is_spec     = (c == xmt_pkg::CH_LT) || (c == xmt_pkg::CH_GT) ||
                         (c == xmt_pkg::CH_SLASH) || (c == xmt_pkg::CH_EQ) ||
                         (c == xmt_pkg::CH_QMARK);
    assign limit       = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
    assign sym_len_inc = sym_len_reg + 8'd1;
    assign sym_last    = (sym_len_inc >= limit);
    assign line_inc    = (c == xmt_pkg::CH_LF && line_reg != 16'hFFFF) ?
                         line_reg + 16'd1 : line_reg;

    // Entity lookup, lowest table entry wins
    always_comb
    begin
        logic match;
        ent_hit  = 1'b0;
        ent_char = 8'h00;
        for (int e = xmt_pkg::ENT_COUNT - 1; e >= 0; e--)
        begin
            match = (ent_len_reg == LENW'(xmt_pkg::ENT_LEN[e])) && !ent_long_reg;
            for (int i = 0; i < xmt_pkg::ENT_NAME_LEN; i++)
            begin
                if (i < int'(xmt_pkg::ENT_LEN[e]) &&
                    ent_name_reg[IDXW'(i)] != xmt_pkg::ENT_NAME[e][i])
                begin
                    match = 1'b0;
                end
            end
            if (match)
            begin
                ent_hit  = 1'b1;
                ent_char = xmt_pkg::ENT_CHAR[e];
            end
        end
    end

    // Next state and results of one step
    always_comb
    begin
        xmt_pkg::scan_result_t r;
        r.count        = 2'd0;
        r.res0         = xmt_pkg::mk_result(8'h00, 1'b0, xmt_pkg::KIND_SPECIAL, 1'b0,
                                            line_reg);
        r.res1         = r.res0;
        mode_next      = mode_reg;
        sym_len_next   = sym_len_reg;
        ent_len_next   = ent_len_reg;
        ent_long_next  = ent_long_reg;
        line_next      = line_reg;
        ent_wr         = 1'b0;

        if (item.end_of_text)
        begin
            if (mode_reg == MODE_SYMBOL)
            begin
                r.res0  = xmt_pkg::mk_result(8'h00, 1'b0, xmt_pkg::KIND_SYMBOL, 1'b1,
                                             line_reg);
                r.count = 2'd1;
            end
            else if (mode_reg != MODE_IDLE)
            begin
                r.res0  = xmt_pkg::mk_result(8'h00, 1'b0, xmt_pkg::KIND_STRING, 1'b1,
                                             line_reg);
                r.count = 2'd1;
            end
            mode_next     = MODE_IDLE;
            sym_len_next  = 8'd0;
            ent_len_next  = '0;
            ent_long_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_SYMBOL:
                begin
                    if (is_ws)
                    begin
                        r.res0       = xmt_pkg::mk_result(8'h00, 1'b0, xmt_pkg::KIND_SYMBOL,
                                                          1'b1, line_reg);
                        r.count      = 2'd1;
                        mode_next    = MODE_IDLE;
                        sym_len_next = 8'd0;
                        line_next    = line_inc;
                    end
                    else if (is_spec)
                    begin
                        // symbol end marker first, then the special
                        r.res0       = xmt_pkg::mk_result(8'h00, 1'b0, xmt_pkg::KIND_SYMBOL,
                                                          1'b1, line_reg);
                        r.res1       = xmt_pkg::mk_result(c, 1'b1, xmt_pkg::KIND_SPECIAL,
                                                          1'b1, line_reg);
                        r.count      = 2'd2;
                        mode_next    = MODE_IDLE;
                        sym_len_next = 8'd0;
                    end
                    else
                    begin
                        r.res0       = xmt_pkg::mk_result(c, 1'b1, xmt_pkg::KIND_SYMBOL,
                                                          sym_last, line_reg);
                        r.count      = 2'd1;
                        mode_next    = sym_last ? MODE_IDLE : MODE_SYMBOL;
                        sym_len_next = sym_last ? 8'd0 : sym_len_inc;
                    end
                end
                MODE_STRING:
                begin
                    if (c == xmt_pkg::CH_DQUOTE)
                    begin
                        r.res0    = xmt_pkg::mk_result(8'h00, 1'b0, xmt_pkg::KIND_STRING,
                                                       1'b1, line_reg);
                        r.count   = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else if (c == xmt_pkg::CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (c == xmt_pkg::CH_AMP)
                    begin
                        mode_next     = MODE_ENTITY;
                        ent_len_next  = '0;
                        ent_long_next = 1'b0;
                    end
                    else
                    begin
                        r.res0  = xmt_pkg::mk_result(c, 1'b1, xmt_pkg::KIND_STRING, 1'b0,
                                                     line_reg);
                        r.count = 2'd1;
                    end
                end
                MODE_ESCAPE:
                begin
                    // unknown escapes are dropped
                    r.count = 2'd1;
                    if (c == xmt_pkg::CH_LOW_N)
                        r.res0 = xmt_pkg::mk_result(xmt_pkg::CH_LF, 1'b1,
                                                    xmt_pkg::KIND_STRING, 1'b0, line_reg);
                    else if (c == xmt_pkg::CH_LOW_T)
                        r.res0 = xmt_pkg::mk_result(xmt_pkg::CH_TAB, 1'b1,
                                                    xmt_pkg::KIND_STRING, 1'b0, line_reg);
                    else if (c == xmt_pkg::CH_LOW_R)
                        r.res0 = xmt_pkg::mk_result(xmt_pkg::CH_CR, 1'b1,
                                                    xmt_pkg::KIND_STRING, 1'b0, line_reg);
                    else if (c == xmt_pkg::CH_BSLASH)
                        r.res0 = xmt_pkg::mk_result(xmt_pkg::CH_BSLASH, 1'b1,
                                                    xmt_pkg::KIND_STRING, 1'b0, line_reg);
                    else
                        r.count = 2'd0;
                    mode_next = MODE_STRING;
                end
                MODE_ENTITY:
                begin
                    if (c == xmt_pkg::CH_SEMI)
                    begin
                        if (ent_hit)
                        begin
                            r.res0  = xmt_pkg::mk_result(ent_char, 1'b1,
                                                         xmt_pkg::KIND_STRING, 1'b0, line_reg);
                            r.count = 2'd1;
                        end
                        ent_len_next  = '0;
                        ent_long_next = 1'b0;
                        mode_next     = MODE_STRING;
                    end
                    else if (ent_len_reg < LENW'(ENTITY_NAME_MAX))
                    begin
                        ent_wr       = 1'b1;
                        ent_len_next = ent_len_reg + LENW'(1);
                    end
                    else
                    begin
                        ent_long_next = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    if (is_ws)
                    begin
                        line_next = line_inc;
                    end
                    else if (is_spec)
                    begin
                        r.res0  = xmt_pkg::mk_result(c, 1'b1, xmt_pkg::KIND_SPECIAL, 1'b1,
                                                     line_reg);
                        r.count = 2'd1;
                    end
                    else if (c == xmt_pkg::CH_DQUOTE)
                    begin
                        mode_next = MODE_STRING;
                    end
                    else
                    begin
                        // first symbol byte; length is zero while idle
                        r.res0       = xmt_pkg::mk_result(c, 1'b1, xmt_pkg::KIND_SYMBOL,
                                                          sym_last, line_reg);
                        r.count      = 2'd1;
                        mode_next    = sym_last ? MODE_IDLE : MODE_SYMBOL;
                        sym_len_next = sym_last ? 8'd0 : sym_len_inc;
                    end
                end
            endcase
        end

        // flag the last result of this byte
        if (r.count == 2'd1)
            r.res0.last_of_run = 1'b1;
        if (r.count == 2'd2)
            r.res1.last_of_run = 1'b1;
        result = r;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            limit_reg    <= xmt_pkg::SYM_LIMIT_RESET;
            sym_len_reg  <= 8'd0;
            ent_len_reg  <= '0;
            ent_long_reg <= 1'b0;
            line_reg     <= 16'd1;
        end
        else
        begin
            if (cfg_wr)
                limit_reg <= cfg_data;
            if (step)
            begin
                mode_reg     <= mode_next;
                sym_len_reg  <= sym_len_next;
                ent_len_reg  <= ent_len_next;
                ent_long_reg <= ent_long_next;
                line_reg     <= line_next;
            end
        end
    end

    // Entity name bytes, read only after being written
    always_ff @(posedge clk)
    begin
        if (step && ent_wr)
            ent_name_reg[ent_len_reg[IDXW-1:0]] <= c;
    end

endmodule

// ----- rtl/xmt_outq.sv -----
// Result queue: takes up to two results per cycle, hands out one per transfer.
module xmt_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  xmt_pkg::scan_result_t  result,
    output logic                   room2,
    output logic                   out_valid,
    input  logic                   out_ready,
    output xmt_pkg::out_item_t     out_item
);

    localparam int PW = $clog2(xmt_pkg::OUTQ_DEPTH);
    localparam int CW = $clog2(xmt_pkg::OUTQ_DEPTH + 1);

    xmt_pkg::out_item_t mem [xmt_pkg::OUTQ_DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         push_cnt;
    logic               pop;

    assign push_cnt  = push ? result.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign room2     = (count_reg <= CW'(xmt_pkg::OUTQ_DEPTH - 2));

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= result.res0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_reg + PW'(1)] <= result.res1;
    end

endmodule

// ----- rtl/xml_markup_tokenizer.sv -----
// Top level of the XML markup tokenizer.
//
// Channels (valid/ready, a transfer when both are high at a rising edge):
//   markup : one raw byte per transfer, or an end_of_text mark that closes
//            any open token.
//   tokens : decoded token results; each carries the byte (when has_byte),
//            its kind, end-of-token and end-of-run flags and the line count.
//   cfg    : writes max_symbol_length; always ready. Write only while idle.
// Order: a taken byte is held in the input register, decoded by the scanner
//   when it steps, and its results go into the result queue that feeds tokens.
// Throughput: one byte per cycle while the queue has room for two results.
//   A byte that gives two results (symbol end marker plus a special) occupies
//   the tokens side for two transfers; the four-entry result queue absorbs that.
// Stall: when the queue cannot take two more results the input register
//   holds its byte and markup.ready drops; nothing is lost.
// Reset: scanner idle, line count one, limit 254, queue empty.
module xml_markup_tokenizer #(
    parameter int ENTITY_NAME_MAX = xmt_pkg::ENTITY_NAME_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    xmt_stream_if.sink     markup,
    xmt_stream_if.source   tokens,
    xmt_stream_if.sink     cfg
);

    logic                  in_vld_reg, in_vld_next;
    xmt_pkg::in_item_t     in_item_reg;
    logic                  step;
    logic                  room2;
    xmt_pkg::scan_result_t scan_res;
    xmt_pkg::cfg_item_t    cfg_item;

    assign cfg_item     = cfg.payload;
    assign cfg.ready    = 1'b1;
    assign step         = in_vld_reg && room2;
    assign markup.ready = !in_vld_reg || step;
    assign in_vld_next  = markup.ready ? markup.valid : in_vld_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (markup.valid && markup.ready)
            in_item_reg <= markup.payload;
    end

    xmt_scan #(
        .ENTITY_NAME_MAX (ENTITY_NAME_MAX)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (in_item_reg),
        .cfg_wr   (cfg.valid),
        .cfg_data (cfg_item.max_symbol_length),
        .result   (scan_res)
    );

    xmt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .result    (scan_res),
        .room2     (room2),
        .out_valid (tokens.valid),
        .out_ready (tokens.ready),
        .out_item  (tokens.payload)
    );

endmodule

// ----- rtl/xmt_checker.sv -----
// Port-level checks for the XML markup tokenizer, bound to the top level.
module xmt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               tok_valid,
    input logic               tok_ready,
    input xmt_pkg::out_item_t tok_item
);

    // A stalled result holds its value
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
        else $error("stalled result changed");

    // A bare end marker carries no byte and closes its token
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_item.has_byte |->
            tok_item.out_byte == 8'h00 && tok_item.last_of_token &&
            tok_item.token_kind != xmt_pkg::KIND_SPECIAL)
        else $error("malformed end marker");

    // A special token is a single byte with both closing flags
    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.token_kind == xmt_pkg::KIND_SPECIAL |->
            tok_item.has_byte && tok_item.last_of_token && tok_item.last_of_run)
        else $error("malformed special token");

    // Line count never falls to zero and kind stays in range
    a_line_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_item.line_number != 16'd0 &&
            (tok_item.token_kind == xmt_pkg::KIND_SPECIAL ||
             tok_item.token_kind == xmt_pkg::KIND_STRING ||
             tok_item.token_kind == xmt_pkg::KIND_SYMBOL))
        else $error("bad line number or token kind");

endmodule

bind xml_markup_tokenizer xmt_checker u_xmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tokens.valid),
    .tok_ready (tokens.ready),
    .tok_item  (tokens.payload)
);
